### design/pali_pkg.sv
`default_nettype none
package pali_pkg;
   localparam int MaxPoints = 256;
   localparam int AddrW = $clog2(MaxPoints);
   localparam int CntW = AddrW + 1;
   localparam int CoordW = 32;
   localparam int LenW = 40;
   localparam logic [LenW-1:0] LenMax = {1'b0, {(LenW-1){1'b1}}};

   localparam logic [1:0] OP_CLEAR  = 2'd0;
   localparam logic [1:0] OP_APPEND = 2'd1;
   localparam logic [1:0] OP_QUERY  = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   // controller to datapath
   typedef struct packed {
      logic             load;      // capture request fields
      logic             rd_en;     // read stores at rd_addr
      logic [AddrW-1:0] rd_addr;
      logic             cap_prev;  // latch read data as previous point
      logic             cap_cur;   // latch read data as current point
      logic             sqrt_go;   // start square root
      logic             div_go;    // start the three divisions
      logic             wr_en;     // write appended point
      logic [AddrW-1:0] wr_addr;
      logic             first_pt;  // appended point is the first one
      logic [1:0]       sel;       // result select
   } ctl_type;

   typedef struct packed {
      logic len_ge;      // read length not below query
      logic sqrt_done;
      logic div_done;
   } sts_type;

   localparam logic [1:0] SEL_ZERO = 2'd0;
   localparam logic [1:0] SEL_CUR  = 2'd1;
   localparam logic [1:0] SEL_LERP = 2'd2;
endpackage
`default_nettype wire

### design/pali_ram.sv
`default_nettype none
module pali_ram #(
   parameter int Width = 32,
   parameter int Depth = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      if (rd_en) rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

### design/pali_datapath.sv
`default_nettype none
module pali_datapath import pali_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire ctl_type                  ctl,
   output sts_type                       sts,
   input  wire logic signed [CoordW-1:0] req_point_x,
   input  wire logic signed [CoordW-1:0] req_point_y,
   input  wire logic signed [CoordW-1:0] req_point_z,
   input  wire logic signed [LenW-1:0]   req_query_depth,
   output logic signed [CoordW-1:0]      res_x,
   output logic signed [CoordW-1:0]      res_y,
   output logic signed [CoordW-1:0]      res_z
);
   logic signed [CoordW-1:0] px_ff, py_ff, pz_ff;
   logic signed [LenW-1:0]   q_ff;
   logic signed [CoordW-1:0] rdx, rdy, rdz;
   logic signed [LenW-1:0]   rdl;
   logic signed [CoordW-1:0] ax_ff, ay_ff, az_ff, bx_ff, by_ff, bz_ff;
   logic signed [LenW-1:0]   al_ff, bl_ff;
   logic [LenW-1:0]          new_len;

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         px_ff <= req_point_x; py_ff <= req_point_y; pz_ff <= req_point_z;
         q_ff  <= req_query_depth;
      end
      if (ctl.cap_prev) begin
         ax_ff <= rdx; ay_ff <= rdy; az_ff <= rdz; al_ff <= rdl;
      end
      if (ctl.cap_cur) begin
         bx_ff <= rdx; by_ff <= rdy; bz_ff <= rdz; bl_ff <= rdl;
      end
   end

   pali_ram #(.Width(CoordW), .Depth(MaxPoints)) u_ram_x (.clock, .wr_en(ctl.wr_en),
      .wr_addr(ctl.wr_addr), .wr_data(px_ff), .rd_en(ctl.rd_en), .rd_addr(ctl.rd_addr),
      .rd_data(rdx));
   pali_ram #(.Width(CoordW), .Depth(MaxPoints)) u_ram_y (.clock, .wr_en(ctl.wr_en),
      .wr_addr(ctl.wr_addr), .wr_data(py_ff), .rd_en(ctl.rd_en), .rd_addr(ctl.rd_addr),
      .rd_data(rdy));
   pali_ram #(.Width(CoordW), .Depth(MaxPoints)) u_ram_z (.clock, .wr_en(ctl.wr_en),
      .wr_addr(ctl.wr_addr), .wr_data(pz_ff), .rd_en(ctl.rd_en), .rd_addr(ctl.rd_addr),
      .rd_data(rdz));
   pali_ram #(.Width(LenW), .Depth(MaxPoints)) u_ram_l (.clock, .wr_en(ctl.wr_en),
      .wr_addr(ctl.wr_addr), .wr_data(new_len), .rd_en(ctl.rd_en), .rd_addr(ctl.rd_addr),
      .rd_data(rdl));

   assign sts.len_ge = !(rdl < q_ff);

   // ---------------- square root of squared distance ----------------
   // squares one per cycle, then restoring root one bit per cycle
   localparam int DW = CoordW + 1;
   localparam int SqW = 2 * DW + 2;
   localparam int RtW = SqW / 2;
   logic [DW-1:0]        dsel;
   logic [1:0]           sq_k_ff;
   logic [SqW-1:0]       rad_ff;      // remaining radicand
   logic [RtW+1:0]       rem_ff;
   logic [RtW-1:0]       root_ff;
   logic [$clog2(RtW+1)-1:0] rcnt_ff;
   logic                 sq_run_ff, rt_run_ff, sqrt_done_ff;
   logic [2*DW-1:0]      sq_prod_ff;
   logic                 sq_pv_ff;
   logic [RtW+1:0]       trial;
   logic signed [DW-1:0] dd;

   always_comb begin
      unique case (sq_k_ff)
         2'd0:    dd = DW'(px_ff) - DW'(ax_ff);
         2'd1:    dd = DW'(py_ff) - DW'(ay_ff);
         default: dd = DW'(pz_ff) - DW'(az_ff);
      endcase
      dsel = dd[DW-1] ? DW'(-dd) : DW'(dd);
   end
   assign trial = {rem_ff[RtW-1:0], rad_ff[SqW-1 -: 2]} - {root_ff, 2'b01};

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_run_ff <= 1'b0; rt_run_ff <= 1'b0; sqrt_done_ff <= 1'b0; sq_pv_ff <= 1'b0;
      end else begin
         sqrt_done_ff <= 1'b0;
         sq_pv_ff <= sq_run_ff;
         if (ctl.sqrt_go) begin
            sq_run_ff <= 1'b1; sq_k_ff <= 2'd0; rad_ff <= '0;
         end else if (sq_run_ff) begin
            sq_k_ff <= sq_k_ff + 2'd1;
            if (sq_k_ff == 2'd2) sq_run_ff <= 1'b0;
         end
         if (sq_run_ff) sq_prod_ff <= dsel * dsel;
         if (sq_pv_ff) begin
            rad_ff <= rad_ff + SqW'(sq_prod_ff);
            if (!sq_run_ff) begin
               rt_run_ff <= 1'b1; rem_ff <= '0; root_ff <= '0;
               rcnt_ff <= ($clog2(RtW+1))'(RtW);
            end
         end
         if (rt_run_ff) begin
            rad_ff <= rad_ff << 2;
            if (!trial[RtW+1]) begin
               rem_ff <= trial; root_ff <= {root_ff[RtW-2:0], 1'b1};
            end else begin
               rem_ff <= {rem_ff[RtW-1:0], rad_ff[SqW-1 -: 2]};
               root_ff <= {root_ff[RtW-2:0], 1'b0};
            end
            rcnt_ff <= rcnt_ff - 1'b1;
            if (rcnt_ff == 1) begin
               rt_run_ff <= 1'b0; sqrt_done_ff <= 1'b1;
            end
         end
      end
   end
   assign sts.sqrt_done = sqrt_done_ff;

   // saturating cumulative length
   logic [LenW:0] lsum;
   assign lsum = {1'b0, al_ff} + (LenW+1)'(root_ff);
   always_comb begin
      if (ctl.first_pt) new_len = '0;
      else if (lsum > (LenW+1)'(LenMax)) new_len = LenMax;
      else new_len = lsum[LenW-1:0];
   end

   // ---------------- three parallel multiply-dividers ----------------
   // q = |p1-p0| * num / den, one bit of |p1-p0| per cycle: shift-add of num
   // with the remainder kept below den by at most two subtractions
   localparam int MW = CoordW + 1;
   localparam int DcW = $clog2(CoordW + 1);
   logic [LenW-1:0]   num_ff, den_ff;
   logic [CoordW-1:0] mg_ff [3];
   logic [CoordW-1:0] quo_ff [3];
   logic [LenW-1:0]   rm_ff [3];
   logic [LenW+1:0]   acc [3];
   logic [CoordW-1:0] mag [3];
   logic              neg [3];
   logic signed [MW-1:0] df [3];
   logic [DcW-1:0]    dcnt_ff;
   logic [1:0]        dph_ff;      // 0 idle 1 setup 2 step
   logic              div_done_ff;

   always_comb begin
      df[0] = MW'(bx_ff) - MW'(ax_ff);
      df[1] = MW'(by_ff) - MW'(ay_ff);
      df[2] = MW'(bz_ff) - MW'(az_ff);
      for (int k = 0; k < 3; k++) begin
         neg[k] = df[k][MW-1];
         mag[k] = neg[k] ? CoordW'(-df[k]) : CoordW'(df[k]);
         acc[k] = {1'b0, rm_ff[k], 1'b0} + (mg_ff[k][CoordW-1] ? {2'b00, num_ff} : '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dph_ff <= 2'd0; div_done_ff <= 1'b0;
      end else begin
         div_done_ff <= 1'b0;
         unique case (dph_ff)
            2'd0: if (ctl.div_go) dph_ff <= 2'd1;
            2'd1: begin
               // previous point is latched by now
               num_ff <= q_ff - al_ff; den_ff <= bl_ff - al_ff;
               for (int k = 0; k < 3; k++) begin
                  mg_ff[k] <= mag[k]; rm_ff[k] <= '0; quo_ff[k] <= '0;
               end
               dcnt_ff <= DcW'(CoordW);
               dph_ff <= 2'd2;
            end
            default: begin
               for (int k = 0; k < 3; k++) begin
                  if (acc[k] >= {1'b0, den_ff, 1'b0}) begin
                     rm_ff[k] <= LenW'(acc[k] - {1'b0, den_ff, 1'b0});
                     quo_ff[k] <= {quo_ff[k][CoordW-2:0], 1'b0} + CoordW'(2);
                  end else if (acc[k] >= {2'b00, den_ff}) begin
                     rm_ff[k] <= LenW'(acc[k] - {2'b00, den_ff});
                     quo_ff[k] <= {quo_ff[k][CoordW-2:0], 1'b1};
                  end else begin
                     rm_ff[k] <= acc[k][LenW-1:0];
                     quo_ff[k] <= {quo_ff[k][CoordW-2:0], 1'b0};
                  end
                  mg_ff[k] <= {mg_ff[k][CoordW-2:0], 1'b0};
               end
               dcnt_ff <= dcnt_ff - 1'b1;
               if (dcnt_ff == DcW'(1)) begin
                  dph_ff <= 2'd0; div_done_ff <= 1'b1;
               end
            end
         endcase
      end
   end
   assign sts.div_done = div_done_ff;

   logic [CoordW-1:0] lx, ly, lz;
   assign lx = neg[0] ? ax_ff - quo_ff[0] : ax_ff + quo_ff[0];
   assign ly = neg[1] ? ay_ff - quo_ff[1] : ay_ff + quo_ff[1];
   assign lz = neg[2] ? az_ff - quo_ff[2] : az_ff + quo_ff[2];

   always_comb begin
      unique case (ctl.sel)
         SEL_CUR:  begin res_x = bx_ff; res_y = by_ff; res_z = bz_ff; end
         SEL_LERP: begin res_x = lx; res_y = ly; res_z = lz; end
         default:  begin res_x = '0; res_y = '0; res_z = '0; end
      endcase
   end
endmodule
`default_nettype wire

### design/pali_ctrl.sv
`default_nettype none
module pali_ctrl import pali_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output logic            busy,
   input  wire logic [1:0] req_opcode,
   output ctl_type         ctl,
   input  wire sts_type    sts,
   output logic            done,
   output logic [1:0]      status
);
   localparam logic [3:0] S_IDLE = 4'd0, S_DEC = 4'd1, S_ARD = 4'd2, S_ACAP = 4'd3,
      S_SQRT = 4'd4, S_AWR = 4'd5, S_QRD = 4'd6, S_QCMP = 4'd7, S_QPRV = 4'd8,
      S_QPCAP = 4'd9, S_QDIV = 4'd10, S_OUT = 4'd11;

   logic [3:0]      state_ff, state_in;
   logic [1:0]      op_ff;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic [CntW-1:0] idx_ff, idx_in;
   logic [1:0]      sel_ff, sel_in, st_ff, st_in;
   logic [1:0]      op_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; cnt_ff <= '0; idx_ff <= '0;
         sel_ff <= SEL_ZERO; st_ff <= ST_OK; op_ff <= OP_CLEAR;
      end else begin
         state_ff <= state_in; cnt_ff <= cnt_in; idx_ff <= idx_in;
         sel_ff <= sel_in; st_ff <= st_in; op_ff <= op_in;
      end
   end

   always_comb begin
      state_in = state_ff; cnt_in = cnt_ff; idx_in = idx_ff;
      sel_in = sel_ff; st_in = st_ff; op_in = op_ff;
      ctl = '0;
      ctl.sel = sel_ff;
      ctl.wr_addr = cnt_ff[AddrW-1:0];
      ctl.first_pt = (cnt_ff == '0);
      ctl.rd_addr = idx_ff[AddrW-1:0];
      done = 1'b0;
      unique case (state_ff)
         S_IDLE: if (start) begin
            ctl.load = 1'b1; op_in = req_opcode; state_in = S_DEC;
            sel_in = SEL_ZERO; st_in = ST_OK;
         end
         S_DEC: begin
            unique case (op_ff)
               OP_CLEAR: begin cnt_in = '0; state_in = S_OUT; end
               OP_APPEND: begin
                  if (cnt_ff == CntW'(MaxPoints)) begin
                     st_in = ST_FULL; state_in = S_OUT;
                  end else if (cnt_ff == '0) state_in = S_AWR;
                  else begin
                     idx_in = cnt_ff - 1'b1; state_in = S_ARD;
                  end
               end
               OP_QUERY: begin
                  if (cnt_ff == '0) begin
                     st_in = ST_EMPTY; state_in = S_OUT;
                  end else begin
                     idx_in = '0; state_in = S_QRD;
                  end
               end
               default: state_in = S_OUT;
            endcase
         end
         S_ARD: begin ctl.rd_en = 1'b1; state_in = S_ACAP; end
         S_ACAP: begin ctl.cap_prev = 1'b1; ctl.sqrt_go = 1'b1; state_in = S_SQRT; end
         S_SQRT: if (sts.sqrt_done) state_in = S_AWR;
         S_AWR: begin
            ctl.wr_en = 1'b1; cnt_in = cnt_ff + 1'b1; state_in = S_OUT;
         end
         S_QRD: begin ctl.rd_en = 1'b1; state_in = S_QCMP; end
         S_QCMP: begin
            ctl.cap_cur = 1'b1;
            if (sts.len_ge || idx_ff == cnt_ff - 1'b1) begin
               // first entry, no entry found, or the target segment
               if (idx_ff == '0 || !sts.len_ge) begin
                  sel_in = SEL_CUR; state_in = S_OUT;
               end else begin
                  idx_in = idx_ff - 1'b1; state_in = S_QPRV;
               end
            end else begin
               idx_in = idx_ff + 1'b1; state_in = S_QRD;
            end
         end
         S_QPRV: begin ctl.rd_en = 1'b1; state_in = S_QPCAP; end
         S_QPCAP: begin ctl.cap_prev = 1'b1; ctl.div_go = 1'b1; state_in = S_QDIV; end
         S_QDIV: if (sts.div_done) begin sel_in = SEL_LERP; state_in = S_OUT; end
         S_OUT: begin done = 1'b1; state_in = S_IDLE; end
         default: state_in = S_IDLE;
      endcase
   end

   assign busy = (state_ff != S_IDLE);
   assign status = st_ff;

   ap_count: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CntW'(MaxPoints)) else $error("point count overflow");
   ap_write_room: assert property (@(posedge clock) disable iff (reset)
      ctl.wr_en |-> cnt_ff < CntW'(MaxPoints)) else $error("write beyond table");
   ap_done_once: assert property (@(posedge clock) disable iff (reset)
      done |=> !done) else $error("double result");
   ap_idle_after: assert property (@(posedge clock) disable iff (reset)
      done |=> state_ff == S_IDLE) else $error("no return to idle");
endmodule
`default_nettype wire

### design/polyline_arc_length_interpolator.sv
`default_nettype none
// polyline arc-length interpolator: holds up to 256 3-d points with their running
// path length and answers "which point lies at this length". drive start with the
// request fields while busy is low; exactly one result beat follows, marked by
// rsp_valid for one cycle, and must be taken then since there is no back-pressure.
// clear and undefined opcodes finish straight after decode; an append runs the
// 34-step bit-serial square root of the squared segment length; a query scans
// the stored points in order and, when it interpolates, runs the 32-step serial
// multiply-divide on all three coordinates at once.
module polyline_arc_length_interpolator import pali_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   output logic                          busy,
   input  wire logic [1:0]               req_opcode,
   input  wire logic signed [CoordW-1:0] req_point_x,
   input  wire logic signed [CoordW-1:0] req_point_y,
   input  wire logic signed [CoordW-1:0] req_point_z,
   input  wire logic signed [LenW-1:0]   req_query_depth,
   output logic                          rsp_valid,
   output logic signed [CoordW-1:0]      rsp_out_x,
   output logic signed [CoordW-1:0]      rsp_out_y,
   output logic signed [CoordW-1:0]      rsp_out_z,
   output logic [1:0]                    rsp_status
);
   ctl_type ctl;
   sts_type sts;
   logic    done;
   logic [1:0] status;

   // sequencer: opcode decode, table scan, unit start/finish
   pali_ctrl u_ctrl (.clock, .reset, .start, .busy, .req_opcode, .ctl, .sts,
      .done, .status);

   // stores, square root, dividers and result mux
   pali_datapath u_dp (.clock, .reset, .ctl, .sts, .req_point_x, .req_point_y,
      .req_point_z, .req_query_depth, .res_x(rsp_out_x), .res_y(rsp_out_y),
      .res_z(rsp_out_z));

   assign rsp_valid  = done;
   assign rsp_status = status;
endmodule
`default_nettype wire
